@@ rtl/bb3_pkg.sv @@
// Shared types, constants and the reciprocal table for the 3x3 box blur.
package bb3_pkg;

  // Line store depth and the widths that follow from it
  localparam int MaxWidth    = 1024;
  localparam int ColW        = $clog2(MaxWidth);
  localparam int WidthW      = 11;
  localparam int HeightW     = 13;
  localparam int HeightLimit = 4096;
  localparam int CfgDataW    = 13;

  // Window sums: nine 8-bit samples
  localparam int SumW   = 12;
  localparam int CntW   = 4;
  localparam int NumW   = SumW + 1;
  localparam int RecipW = 18;
  localparam int RecipShift = 18;
  localparam int ProdW  = NumW + RecipW;

  typedef enum logic [0:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
  } sum_t;

  // ceil(2^18 / (2*n)); exact quotient for numerators below 2^13
  function automatic logic [RecipW-1:0] recip_f(input logic [CntW-1:0] cnt);
    logic [RecipW-1:0] m;
    case (cnt)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = 18'd131072;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/bb3_mean.sv @@
// Rounded mean of the three channel sums: reciprocal multiply, one register stage.
module bb3_mean (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  bb3_pkg::sum_t            sum_i,
  input  logic [bb3_pkg::CntW-1:0] cnt_i,
  output bb3_pkg::rgb_t            mean_o
);

  logic [bb3_pkg::RecipW-1:0] recip;
  logic [bb3_pkg::NumW-1:0]   num_r, num_g, num_b;
  logic [bb3_pkg::ProdW-1:0]  prod_r_q, prod_g_q, prod_b_q;

  // floor((2*sum + n) / (2*n))
  assign recip = bb3_pkg::recip_f(cnt_i);
  assign num_r = {sum_i.red, 1'b0} + bb3_pkg::NumW'(cnt_i);
  assign num_g = {sum_i.green, 1'b0} + bb3_pkg::NumW'(cnt_i);
  assign num_b = {sum_i.blue, 1'b0} + bb3_pkg::NumW'(cnt_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_r_q <= bb3_pkg::ProdW'(num_r) * bb3_pkg::ProdW'(recip);
      prod_g_q <= bb3_pkg::ProdW'(num_g) * bb3_pkg::ProdW'(recip);
      prod_b_q <= bb3_pkg::ProdW'(num_b) * bb3_pkg::ProdW'(recip);
    end
  end

  assign mean_o.red   = prod_r_q[bb3_pkg::RecipShift +: 8];
  assign mean_o.green = prod_g_q[bb3_pkg::RecipShift +: 8];
  assign mean_o.blue  = prod_b_q[bb3_pkg::RecipShift +: 8];

endmodule

@@ rtl/box_blur_3x3_edge_aware.sv @@
// Streaming 3x3 box blur of an RGB raster, averaging only neighbors inside the frame.
//
// Pixels enter in raster order; each result is the rounded-half-up mean of the
// in-frame pixels around one position (9, 6 or 4 of them, fewer in thin frames).
// Results lag the input by frame_width+1 positions: after the last pixel send
// frame_width+1 flush beats (tuser = 1) to drain. A flush beat inside the frame
// is dropped. tlast marks the last pixel of a row, tuser on the result marks the
// last pixel of the frame. One item is worked at a time: a beat that yields no
// result passes a line store read, then write-back and window shift; a beat
// that yields a result adds window sum, reciprocal multiply and output load
// (which waits while the output register is full). The next beat is taken while a
// result waits in the output register. A write to either register restarts the frame; write only when idle.
module box_blur_3x3_edge_aware (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [0:0]                   cfg_index_i,
  input  logic [bb3_pkg::CfgDataW-1:0] cfg_data_i,
  // pixel input
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,  // in_red, in_green, in_blue
  input  logic                         s_axis_tuser,  // kind
  // blurred output
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // out_red, out_green, out_blue
  output logic                         m_axis_tlast,  // end_of_row
  output logic                         m_axis_tuser   // end_of_frame
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_SUM   = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  localparam int RowExtW = bb3_pkg::HeightW + 1;

  state_e state_q, state_d;

  logic [bb3_pkg::WidthW-1:0]  width_q, w_eff;
  logic [bb3_pkg::HeightW-1:0] height_q, h_eff;
  logic [bb3_pkg::ColW-1:0]    col_q;
  logic [bb3_pkg::HeightW-1:0] row_q;

  bb3_pkg::rgb_t upper_mem [bb3_pkg::MaxWidth];
  bb3_pkg::rgb_t lower_mem [bb3_pkg::MaxWidth];
  bb3_pkg::rgb_t up_rd_q, lo_rd_q, px_q;
  bb3_pkg::rgb_t win_q [9];

  logic [8:0]               mask_q, mask_d;
  logic [bb3_pkg::CntW-1:0] cnt_q;
  logic                     eor_q, eof_q;
  bb3_pkg::sum_t            sum_q, sum_d;
  bb3_pkg::rgb_t            mean;

  logic                m_valid_q;
  bb3_pkg::rgb_t       m_data_q;
  logic                m_last_q, m_user_q;

  logic in_acc, in_frame, start, drop;
  logic out_free, out_load;

  // position decode for the shift stage
  logic [RowExtW-1:0]        r_ext, h_ext;
  logic                      col_zero, emit, eor, eof;
  logic [2:0]                rv, cv;
  logic [bb3_pkg::WidthW-1:0] col_inc;
  logic [RowExtW-1:0]        row_inc;
  logic [bb3_pkg::ColW-1:0]  col_n;
  logic [bb3_pkg::HeightW-1:0] row_n;

  // effective frame size
  always_comb begin
    if (width_q == '0) begin
      w_eff = bb3_pkg::WidthW'(1);
    end else if (width_q > bb3_pkg::WidthW'(bb3_pkg::MaxWidth)) begin
      w_eff = bb3_pkg::WidthW'(bb3_pkg::MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = bb3_pkg::HeightW'(1);
    end else if (height_q > bb3_pkg::HeightW'(bb3_pkg::HeightLimit)) begin
      h_eff = bb3_pkg::HeightW'(bb3_pkg::HeightLimit);
    end else begin
      h_eff = height_q;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_frame      = row_q < h_eff;
  assign drop          = s_axis_tuser && in_frame;
  assign start         = in_acc && !drop;

  // Window geometry. Column 2 of the window is the column just read.
  assign r_ext    = {1'b0, row_q};
  assign h_ext    = {1'b0, h_eff};
  assign col_zero = (col_q == '0);

  always_comb begin
    if (!col_zero) begin
      // center one row up, one column left
      rv   = {r_ext < h_ext, 1'b1, r_ext >= RowExtW'(2)};
      cv   = {1'b1, 1'b1, col_q >= bb3_pkg::ColW'(2)};
      emit = (r_ext >= RowExtW'(1)) && (r_ext <= h_ext);
      eor  = 1'b0;
      eof  = 1'b0;
    end else begin
      // center is the last column, two rows up
      rv   = {r_ext <= h_ext, 1'b1, r_ext >= RowExtW'(3)};
      cv   = {1'b0, 1'b1, w_eff >= bb3_pkg::WidthW'(2)};
      emit = (r_ext >= RowExtW'(2)) && (r_ext <= h_ext + RowExtW'(1));
      eor  = 1'b1;
      eof  = (r_ext == h_ext + RowExtW'(1));
    end
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        mask_d[dy*3+dx] = rv[dy] & cv[dx];
      end
    end
  end

  always_comb begin
    col_inc = {1'b0, col_q} + bb3_pkg::WidthW'(1);
    if (col_inc >= w_eff) begin
      col_n   = '0;
      row_inc = r_ext + RowExtW'(1);
    end else begin
      col_n   = col_inc[bb3_pkg::ColW-1:0];
      row_inc = r_ext;
    end
    if (row_inc > h_ext + RowExtW'(1) || (emit && eof)) begin
      col_n = '0;
      row_n = '0;
    end else begin
      row_n = row_inc[bb3_pkg::HeightW-1:0];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 9; i++) begin
      if (mask_q[i]) begin
        sum_d.red   = sum_d.red   + bb3_pkg::SumW'(win_q[i].red);
        sum_d.green = sum_d.green + bb3_pkg::SumW'(win_q[i].green);
        sum_d.blue  = sum_d.blue  + bb3_pkg::SumW'(win_q[i].blue);
      end
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == S_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_SHIFT;
      S_SHIFT: state_d = emit ? S_SUM : S_IDLE;
      S_SUM:   state_d = S_DIV;
      S_DIV:   state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Line stores: read at accept, write back in the next cycle at the same column
  always_ff @(posedge clk_i) begin
    if (start) begin
      up_rd_q <= upper_mem[col_q];
      lo_rd_q <= lower_mem[col_q];
      // red sits in the low byte of tdata
      px_q    <= in_frame ? {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}
                          : '0;
    end
    if (state_q == S_SHIFT) begin
      upper_mem[col_q] <= lo_rd_q;
      lower_mem[col_q] <= px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SHIFT) begin
      mask_q <= mask_d;
      cnt_q  <= bb3_pkg::CntW'($countones(mask_d));
      eor_q  <= eor;
      eof_q  <= eof;
    end
    if (state_q == S_SUM) begin
      sum_q <= sum_d;
    end
  end

  bb3_mean u_mean (
    .clk_i  (clk_i),
    .en_i   (state_q == S_DIV),
    .sum_i  (sum_q),
    .cnt_i  (cnt_q),
    .mean_o (mean)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      width_q  <= bb3_pkg::WidthW'(1024);
      height_q <= bb3_pkg::HeightW'(768);
      col_q    <= '0;
      row_q    <= '0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SHIFT) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k*3+0] <= win_q[k*3+1];
          win_q[k*3+1] <= win_q[k*3+2];
        end
        win_q[2] <= up_rd_q;
        win_q[5] <= lo_rd_q;
        win_q[8] <= px_q;
        col_q    <= col_n;
        row_q    <= row_n;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bb3_pkg::CfgFrameWidth:  width_q  <= cfg_data_i[bb3_pkg::WidthW-1:0];
          bb3_pkg::CfgFrameHeight: height_q <= cfg_data_i[bb3_pkg::HeightW-1:0];
          default: ;
        endcase
        col_q <= '0;
        row_q <= '0;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= mean;
      m_last_q <= eor_q;
      m_user_q <= eof_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_data_q.blue, m_data_q.green, m_data_q.red};
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

endmodule
